// File: hdl/hrss_pkg.sv
// package: constants, types and tables for the hashed random step sequencer
`timescale 1ns / 1ps
package hrss_pkg;
  localparam int LOOP_MAX = 32;
  localparam int LEN_W = $clog2(LOOP_MAX + 1);

  localparam logic [31:0] MIX_C1 = 32'h7feb352d;
  localparam logic [31:0] MIX_C2 = 32'h846ca68b;
  localparam logic [31:0] GOLDEN = 32'h9E3779B9;
  localparam logic [31:0] PHRASE_SALT = 32'hB1A5C0DE;
  localparam logic [31:0] KEY_BASE = 32'hA5A50000;
  localparam logic [7:0] BREAK_LIMIT = 8'd96;
  localparam logic [18:0] GAP_MIN = 19'd1600;
  // ceil(2^19 / 3): exact thirds for any 19-bit gap after a shift by 19
  localparam logic [17:0] RECIP3 = 18'd174763;

  localparam logic [2:0] MODE_CLOCK = 3'd0;
  localparam logic [2:0] MODE_HAND = 3'd1;
  localparam logic [2:0] MODE_KEYED = 3'd2;
  localparam logic [2:0] MODE_RESET = 3'd3;
  localparam logic [2:0] MODE_LENGTH = 3'd4;

  localparam logic [2:0] REG_SEED = 3'd0;
  localparam logic [2:0] REG_CHANCE = 3'd1;
  localparam logic [2:0] REG_SPREAD = 3'd2;
  localparam logic [2:0] REG_TONE = 3'd3;
  localparam logic [2:0] REG_PITCH = 3'd4;
  localparam logic [2:0] REG_RATCHET = 3'd5;

  typedef struct packed {
    logic [9:0] kick;
    logic [9:0] metal;
    logic [9:0] tone;
    logic [9:0] level;
    logic [9:0] decay;
  } arch_t;

  function automatic arch_t arch_lookup(input logic [2:0] k);
    arch_t a;
    case (k)
      3'd0: a = '{10'd256, 10'd256, 10'd256, 10'd256, 10'd256};
      3'd1: a = '{10'd256, 10'd60, 10'd64, 10'd240, 10'd220};
      3'd2: a = '{10'd50, 10'd256, 10'd256, 10'd256, 10'd256};
      3'd3: a = '{10'd30, 10'd200, 10'd200, 10'd150, 10'd480};
      3'd4: a = '{10'd230, 10'd130, 10'd200, 10'd230, 10'd300};
      3'd5: a = '{10'd16, 10'd256, 10'd256, 10'd130, 10'd600};
      3'd6: a = '{10'd200, 10'd200, 10'd96, 10'd256, 10'd200};
      default: a = '{10'd190, 10'd40, 10'd160, 10'd100, 10'd420};
    endcase
    return a;
  endfunction

  function automatic logic [1:0] ratchet_lookup(input logic [1:0] s);
    logic [1:0] n;
    case (s)
      2'd0: n = 2'd1;
      2'd1: n = 2'd1;
      2'd2: n = 2'd2;
      default: n = 2'd3;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] sat256(input logic [8:0] v);
    return v[8] ? 9'd256 : v;
  endfunction
endpackage

// File: hdl/hashed_random_step_sequencer.sv
// top level: event sequencer with one shared 33x33 signed multiplier
`timescale 1ns / 1ps
// throughput: one item at a time, in_tready stays low until the result is taken; the
//   hash, blend, roll and parameter multiplies and the ratchet divide share one multiplier
// ratchet period: halving, quartering or a reciprocal multiply for thirds
// reset: synchronous active-low rst_n restores registers, step counters and held values
module hashed_random_step_sequencer
  import hrss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[2:0], key_index[7:3], new_length[13:8], clock_gap[32:14], zeros
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // fired[0], kick_on[1], metal_on[2], step_pitch[14:3], level[23:15],
  // noise_blend[32:24], decay_scale[42:33], rust_offset[55:43],
  // pitch_drop[67:56], cv_out[79:68], ratchet_count[81:80],
  // ratchet_period[99:82], zeros
  output logic [103:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  typedef enum logic [4:0] {
    S_IDLE, S_IDX, S_M1, S_M2, S_H2A, S_H2B, S_H3A, S_H3B, S_PHA, S_PHB,
    S_KM, S_MM, S_TM, S_LM, S_DM, S_KC, S_MC, S_NB, S_RP, S_RD, S_RN, S_RR,
    S_RL, S_RE, S_CV, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] seed_r;
  logic [8:0] chance_r, spread_r, tone_r, ratchet_r;
  logic signed [14:0] pbase_r;
  logic [31:0] free_step_r, wbase_r;
  logic [LEN_W-1:0] wphase_r, loop_len_r;
  logic [2:0] mode_r;
  logic keyed_r;
  logic [18:0] gap_r;
  logic [31:0] idx_r, x_r, h_r, h2_r, h3_r;
  logic [2:0] arch_r;
  logic signed [10:0] km_r, mm_r, tm_r, lm_r, dm_r;
  logic kick_r, metal_r, fired_r;
  logic signed [11:0] pitch_r;
  logic [8:0] level_r, noise_r;
  logic [9:0] decay_r;
  logic signed [12:0] rust_r;
  logic [11:0] drop_r, cv_r;
  logic [1:0] rc_r;
  logic [17:0] quo_r;
  logic [8:0] noise_part_r;

  // shared multiplier, 33-bit signed operands
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  arch_t arch;
  assign arch = arch_lookup(arch_r);
  logic [8:0] sp, ch, tb;
  assign sp = sat256(spread_r);
  assign ch = sat256(chance_r);
  assign tb = sat256(tone_r);

  function automatic logic signed [32:0] s8(input logic [7:0] b);
    return 33'(signed'({1'b0, b})) - 33'sd128;
  endfunction
  function automatic logic signed [32:0] dif(input logic [9:0] v);
    return 33'(signed'({1'b0, v})) - 33'sd256;
  endfunction

  always_comb begin
    ma = '0;
    mb = 33'(signed'({1'b0, sp}));
    case (state_r)
      S_IDX: begin ma = signed'({1'b0, idx_r}); mb = signed'({1'b0, GOLDEN}); end
      S_M1, S_H2A, S_H3A, S_PHA: begin
        ma = signed'({1'b0, x_r ^ (x_r >> 16)}); mb = signed'({1'b0, MIX_C1});
      end
      S_M2, S_H2B, S_H3B, S_PHB: begin
        ma = signed'({1'b0, x_r ^ (x_r >> 15)}); mb = signed'({1'b0, MIX_C2});
      end
      S_KM: ma = dif(arch.kick);
      S_MM: ma = dif(arch.metal);
      S_TM: ma = dif(arch.tone);
      S_LM: ma = dif(arch.level);
      S_DM: ma = dif(arch.decay);
      S_KC: begin ma = 33'(km_r); mb = 33'(signed'({1'b0, ch})); end
      S_MC: begin ma = 33'(mm_r); mb = 33'(signed'({1'b0, ch})); end
      S_NB: begin ma = 33'(tm_r); mb = 33'(signed'({1'b0, tb})); end
      S_RP: ma = s8(h_r[15:8]);
      S_RD: ma = s8(h_r[23:16]);
      S_RN: ma = s8(h_r[31:24]);
      S_RR: ma = s8(h2_r[7:0]);
      S_RL: ma = s8(h2_r[15:8]);
      S_RE: ma = s8(h2_r[23:16]);
      S_CV: begin ma = 33'(pbase_r) + 33'(pitch_r); mb = 33'sd341; end
      S_DIV: begin ma = 33'(gap_r); mb = 33'(RECIP3); end
      default: ;
    endcase
  end

  logic [31:0] mlo;
  assign mlo = mp[31:0];

  function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
      input logic signed [31:0] lo, input logic signed [31:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  logic signed [31:0] m32;
  assign m32 = mp[31:0];
  logic [31:0] ph;
  assign ph = mlo ^ (mlo >> 16);

  logic [LEN_W-1:0] nlen;
  logic [5:0] nlen_in;
  assign nlen_in = in_tdata[13:8];
  always_comb begin
    if (nlen_in == 6'd0) nlen = '0;
    else if (nlen_in < 6'd2) nlen = LEN_W'(2);
    else if (32'(nlen_in) > LOOP_MAX) nlen = LEN_W'(LOOP_MAX);
    else nlen = LEN_W'(nlen_in);
  end

  logic accept;
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !in_tvalid;
  assign out_tvalid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seed_r <= 32'd12648430; chance_r <= 9'd256; spread_r <= 9'd128;
      tone_r <= 9'd69; pbase_r <= 15'sd3072; ratchet_r <= '0;
      free_step_r <= '0; wbase_r <= '0; wphase_r <= '0; loop_len_r <= '0;
      pitch_r <= '0; level_r <= 9'd256; noise_r <= 9'd64;
      decay_r <= 10'd256; rust_r <= '0; drop_r <= 12'd512; cv_r <= '0;
      fired_r <= 1'b0; kick_r <= 1'b0; metal_r <= 1'b0; rc_r <= '0; quo_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEED: seed_r <= cfg_data;
          REG_CHANCE: chance_r <= cfg_data[8:0];
          REG_SPREAD: spread_r <= cfg_data[8:0];
          REG_TONE: tone_r <= cfg_data[8:0];
          REG_PITCH: pbase_r <= cfg_data[14:0];
          REG_RATCHET: ratchet_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (accept) begin
          mode_r <= in_tdata[2:0];
          gap_r <= in_tdata[32:14];
          fired_r <= 1'b0; kick_r <= 1'b0; metal_r <= 1'b0;
          rc_r <= '0; quo_r <= '0;
          case (in_tdata[2:0])
            MODE_CLOCK: begin
              idx_r <= (loop_len_r != '0) ? wbase_r + 32'(wphase_r) : free_step_r;
              free_step_r <= free_step_r + 32'd1;
              if (loop_len_r != '0)
                wphase_r <= (wphase_r + LEN_W'(1) >= loop_len_r) ? '0 :
                            wphase_r + LEN_W'(1);
              keyed_r <= 1'b0; state_r <= S_IDX;
            end
            MODE_HAND: begin
              idx_r <= free_step_r; free_step_r <= free_step_r + 32'd1;
              keyed_r <= 1'b1; state_r <= S_IDX;
            end
            MODE_KEYED: begin
              idx_r <= KEY_BASE + 32'(in_tdata[7:3]); keyed_r <= 1'b1; state_r <= S_IDX;
            end
            MODE_RESET: begin
              wphase_r <= '0; state_r <= S_OUT;
            end
            MODE_LENGTH: begin
              if (nlen != loop_len_r) begin
                if (nlen != '0 && loop_len_r == '0) wbase_r <= free_step_r - 32'(nlen);
                wphase_r <= '0; loop_len_r <= nlen;
              end
              state_r <= S_OUT;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_IDX: begin
          x_r <= seed_r ^ mlo; state_r <= S_M1;
        end
        S_M1: begin x_r <= mlo; state_r <= S_M2; end
        S_M2: begin h_r <= ph; x_r <= ph; state_r <= S_H2A; end
        S_H2A: begin x_r <= mlo; state_r <= S_H2B; end
        S_H2B: begin h2_r <= ph; x_r <= ph; state_r <= S_H3A; end
        S_H3A: begin x_r <= mlo; state_r <= S_H3B; end
        S_H3B: begin
          h3_r <= ph;
          x_r <= seed_r ^ PHRASE_SALT ^ (idx_r >> 3);
          state_r <= S_PHA;
        end
        S_PHA: begin x_r <= mlo; state_r <= S_PHB; end
        S_PHB: begin
          arch_r <= (h3_r[7:0] < BREAK_LIMIT) ? h3_r[10:8] : ph[2:0];
          state_r <= S_KM;
        end
        S_KM: begin km_r <= 11'(32'sd256 + (m32 >>> 8)); state_r <= S_MM; end
        S_MM: begin mm_r <= 11'(32'sd256 + (m32 >>> 8)); state_r <= S_TM; end
        S_TM: begin tm_r <= 11'(32'sd256 + (m32 >>> 8)); state_r <= S_LM; end
        S_LM: begin lm_r <= 11'(32'sd256 + (m32 >>> 8)); state_r <= S_DM; end
        S_DM: begin dm_r <= 11'(32'sd256 + (m32 >>> 8)); state_r <= S_KC; end
        S_KC: begin
          kick_r <= keyed_r || (signed'({24'd0, h_r[7:0]}) < (m32 >>> 8));
          state_r <= S_MC;
        end
        S_MC: begin
          metal_r <= keyed_r || (signed'({24'd0, h3_r[23:16]}) < (m32 >>> 8));
          state_r <= S_NB;
        end
        S_NB: begin
          noise_part_r <= 9'(m32 >>> 8);
          if (!kick_r && !metal_r) state_r <= S_OUT;
          else begin fired_r <= 1'b1; state_r <= S_RP; end
        end
        S_RP: begin
          pitch_r <= keyed_r ? 12'sd0 : 12'(m32 >>> 4); state_r <= S_RD;
        end
        S_RD: begin
          decay_r <= 10'(clampv(32'(dm_r) + (m32 >>> 8), 32'sd32, 32'sd768));
          state_r <= S_RN;
        end
        S_RN: begin
          noise_r <= 9'(clampv(32'(signed'({1'b0, noise_part_r})) + (m32 >>> 8),
                               32'sd0, 32'sd256));
          state_r <= S_RR;
        end
        S_RR: begin rust_r <= 13'(m32 >>> 3); state_r <= S_RL; end
        S_RL: begin
          level_r <= 9'(clampv(32'(lm_r) + (m32 >>> 9), 32'sd24, 32'sd256));
          state_r <= S_RE;
        end
        S_RE: begin
          drop_r <= 12'(clampv(32'sd512 + (m32 >>> 4), 32'sd0, 32'sd3072));
          state_r <= S_CV;
        end
        S_CV: begin
          cv_r <= 12'(clampv(m32 >>> 10, -32'sd2048, 32'sd2047));
          if (mode_r == MODE_CLOCK && sat256(ratchet_r) != 9'd0 &&
              {1'b0, h2_r[29:24], 2'b00} < sat256(ratchet_r) && gap_r > GAP_MIN) begin
            rc_r <= ratchet_lookup(h2_r[31:30]);
            state_r <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          // period is the gap over two, three or four
          case (rc_r)
            2'd1: quo_r <= gap_r[18:1];
            2'd2: quo_r <= mp[36:19];
            default: quo_r <= {1'b0, gap_r[18:2]};
          endcase
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {4'd0, quo_r, rc_r, cv_r, drop_r, rust_r, decay_r,
                      noise_r, level_r, pitch_r, metal_r, kick_r, fired_r};
endmodule

// File: hdl/hrss_checker.sv
// port-level checker for the step sequencer, bound to the top level
`timescale 1ns / 1ps
module hrss_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [103:0] out_tdata,
  input logic cfg_ready
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> !out_tdata[1] && !out_tdata[2] && out_tdata[81:80] == 2'd0)
    else $error("skipped step carries hits");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> in_tready) else $error("config taken while busy");
endmodule

bind hashed_random_step_sequencer hrss_checker u_hrss_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .cfg_ready(cfg_ready)
);

// File: bench/tb_top.sv
// testbench for the hashed random step sequencer: scoreboard, drivers and stimulus
`timescale 1ns / 1ps

typedef struct packed {
  logic        fired, kick_on, metal_on;
  logic [11:0] step_pitch;
  logic [8:0]  level, noise_blend;
  logic [9:0]  decay_scale;
  logic [12:0] rust_offset;
  logic [11:0] pitch_drop, cv_out;
  logic [1:0]  ratchet_count;
  logic [17:0] ratchet_period;
} step_result_t;

class step_scoreboard;
  bit [31:0] seed;
  bit [8:0] chance, spread, tone_base, ratchet_amount;
  int pitch_base;
  bit [31:0] free_step, window_base;
  bit [5:0] window_phase, loop_length;
  int h_pitch, h_level, h_noise, h_decay, h_rust, h_drop, h_cv;
  step_result_t pending[$];
  int errors, results;

  function new();
    seed = 32'h00C0FFEE; chance = 256; spread = 128; tone_base = 69;
    pitch_base = 3072; ratchet_amount = 0;
    free_step = 0; window_base = 0; window_phase = 0; loop_length = 0;
    h_pitch = 0; h_level = 256; h_noise = 64;
    h_decay = 256; h_rust = 0; h_drop = 512; h_cv = 0;
    errors = 0; results = 0;
  endfunction

  function bit [31:0] mix(bit [31:0] x);
    x ^= x >> 16; x *= 32'h7feb352d;
    x ^= x >> 15; x *= 32'h846ca68b;
    x ^= x >> 16;
    return x;
  endfunction

  function int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function int sat(bit [8:0] v);
    return v > 256 ? 256 : int'(v);
  endfunction

  function void write_reg(bit [2:0] idx, bit [31:0] v);
    case (idx)
      hrss_pkg::REG_SEED:    seed = v;
      hrss_pkg::REG_CHANCE:  chance = v[8:0];
      hrss_pkg::REG_SPREAD:  spread = v[8:0];
      hrss_pkg::REG_TONE:    tone_base = v[8:0];
      hrss_pkg::REG_PITCH:   pitch_base = int'($signed(v[14:0]));
      hrss_pkg::REG_RATCHET: ratchet_amount = v[8:0];
      default: ;
    endcase
  endfunction

  // blend toward the archetype, scaled by spread; >>> on int is arithmetic
  function int blend(int a, int sp);
    return 256 + (((a - 256) * sp) >>> 8);
  endfunction

  function bit hit_roll(bit [31:0] h, bit [31:0] idx, bit keyed,
                        output bit kick, output bit metal);
    bit [31:0] h2, h3, ph;
    bit [2:0] k;
    int sp, ch, tb, rp, rd, rn, rr, rl, re, km, mm, tm, lm, dm, pitch;
    hrss_pkg::arch_t a;
    h2 = mix(h); h3 = mix(h2);
    sp = sat(spread); ch = sat(chance); tb = sat(tone_base);
    rp = int'(h[15:8]) - 128; rd = int'(h[23:16]) - 128; rn = int'(h[31:24]) - 128;
    rr = int'(h2[7:0]) - 128; rl = int'(h2[15:8]) - 128; re = int'(h2[23:16]) - 128;
    ph = mix(seed ^ 32'hB1A5C0DE ^ (idx >> 3));
    k = ph[2:0];
    if (h3[7:0] < 96) k = h3[10:8];
    a = hrss_pkg::arch_lookup(k);
    km = blend(a.kick, sp); mm = blend(a.metal, sp); tm = blend(a.tone, sp);
    lm = blend(a.level, sp); dm = blend(a.decay, sp);
    kick = keyed || (int'(h[7:0]) < ((ch * km) >>> 8));
    metal = keyed || (int'(h3[23:16]) < ((ch * mm) >>> 8));
    if (!kick && !metal) return 0;
    pitch = keyed ? 0 : ((rp * sp) >>> 4);
    h_pitch = pitch;
    h_level = clip(lm + ((rl * sp) >>> 9), 24, 256);
    h_noise = clip(((tb * tm) >>> 8) + ((rn * sp) >>> 8), 0, 256);
    h_decay = clip(dm + ((rd * sp) >>> 8), 32, 768);
    h_rust = (rr * sp) >>> 3;
    h_drop = clip(512 + ((re * sp) >>> 4), 0, 3072);
    h_cv = clip(((pitch_base + pitch) * 341) >>> 10, -2048, 2047);
    return 1;
  endfunction

  function void note_event(bit [2:0] mode, bit [4:0] key, bit [5:0] nlen, bit [18:0] gap);
    step_result_t r;
    bit [31:0] idx, h, h2;
    bit fired, kick, metal;
    int ra, rc, rper;
    fired = 0; kick = 0; metal = 0; rc = 0; rper = 0;
    case (mode)
      hrss_pkg::MODE_CLOCK: begin
        idx = loop_length != 0 ? window_base + 32'(window_phase) : free_step;
        h = mix(seed ^ (idx * 32'h9E3779B9));
        free_step++;
        if (loop_length != 0) begin
          window_phase++;
          if (window_phase >= loop_length) window_phase = 0;
        end
        fired = hit_roll(h, idx, 0, kick, metal);
        if (fired) begin
          h2 = mix(h);
          ra = sat(ratchet_amount);
          if (ra != 0 && (int'(h2[29:24]) << 2) < ra && gap > 1600) begin
            rc = hrss_pkg::ratchet_lookup(h2[31:30]);
            rper = gap / (rc + 1);
          end
        end
      end
      hrss_pkg::MODE_HAND: begin
        idx = free_step;
        free_step++;
        fired = hit_roll(mix(seed ^ (idx * 32'h9E3779B9)), idx, 1, kick, metal);
      end
      hrss_pkg::MODE_KEYED: begin
        idx = 32'hA5A50000 + 32'(key);
        fired = hit_roll(mix(seed ^ (idx * 32'h9E3779B9)), idx, 1, kick, metal);
      end
      hrss_pkg::MODE_RESET: window_phase = 0;
      hrss_pkg::MODE_LENGTH: begin
        if (nlen != 0)
          nlen = nlen < 2 ? 6'd2 : (nlen > hrss_pkg::LOOP_MAX ? 6'(hrss_pkg::LOOP_MAX) : nlen);
        if (nlen != loop_length) begin
          if (nlen != 0 && loop_length == 0) window_base = free_step - 32'(nlen);
          window_phase = 0;
          loop_length = nlen;
        end
      end
      default: ;
    endcase
    if (!fired) begin
      kick = 0; metal = 0;
    end
    r.fired = fired; r.kick_on = kick; r.metal_on = metal;
    r.step_pitch = 12'(h_pitch); r.level = 9'(h_level); r.noise_blend = 9'(h_noise);
    r.decay_scale = 10'(h_decay); r.rust_offset = 13'(h_rust); r.pitch_drop = 12'(h_drop);
    r.cv_out = 12'(h_cv); r.ratchet_count = 2'(rc); r.ratchet_period = 18'(rper);
    pending.push_back(r);
  endfunction

  function void check_result(logic [103:0] d);
    step_result_t e, g;
    g.fired = d[0]; g.kick_on = d[1]; g.metal_on = d[2];
    g.step_pitch = d[14:3]; g.level = d[23:15]; g.noise_blend = d[32:24];
    g.decay_scale = d[42:33]; g.rust_offset = d[55:43]; g.pitch_drop = d[67:56];
    g.cv_out = d[79:68]; g.ratchet_count = d[81:80]; g.ratchet_period = d[99:82];
    results++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", d);
      return;
    end
    e = pending.pop_front();
    if (e !== g || d[103:100] !== 4'b0) begin
      errors++;
      if (errors <= 10) $display("result %0d mismatch: expected %p got %p", results, e, g);
    end
  endfunction
endclass

module tb_top;
  import hrss_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_valid = 0;
  logic [39:0] in_tdata = '0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [103:0] out_tdata;

  step_scoreboard sb;
  int idle_cycles = 0, sent = 0;
  bit stall_free = 0;

  hashed_random_step_sequencer dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
  endfunction

  // result side: random back-pressure, checks on every accepted item
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (stall_free) out_tready <= 1;
      else begin
        n = gap_len();
        if (n == 0) out_tready <= 1;
        else begin
          out_tready <= 0;
          repeat (n) @(negedge clk);
          out_tready <= 1;
        end
      end
    end
  end

  task automatic send_event(bit [2:0] mode, bit [4:0] key, bit [5:0] nlen, bit [18:0] gap);
    int n;
    n = stall_free ? 0 : gap_len();
    // the block stays busy after each accept until its result is taken
    repeat (n + 1) @(negedge clk);
    in_tdata <= {7'd0, gap, nlen, key, mode};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_event(mode, key, nlen, gap);
    sent++;
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(bit [2:0] idx, bit [31:0] v);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_event();
    int p;
    bit [2:0] m;
    p = $urandom_range(0, 99);
    m = p < 60 ? MODE_CLOCK : p < 72 ? MODE_HAND : p < 84 ? MODE_KEYED :
        p < 90 ? MODE_RESET : p < 97 ? MODE_LENGTH : 3'($urandom_range(5, 7));
    send_event(m, 5'($urandom), $urandom_range(0, 3) == 0 ? 6'($urandom) :
               6'($urandom_range(0, 33)),
               $urandom_range(0, 3) == 0 ? 19'($urandom) : 19'($urandom_range(0, 480000)));
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: every mode, field extremes, length saturation, skipped steps
    send_event(MODE_CLOCK, 0, 0, 0);
    send_event(MODE_HAND, 0, 0, 0);
    send_event(MODE_KEYED, 5'd0, 0, 0);
    send_event(MODE_KEYED, 5'd31, 6'h3f, 19'h7ffff);
    send_event(MODE_LENGTH, 0, 6'd1, 0);
    send_event(MODE_CLOCK, 0, 0, 480000);
    send_event(MODE_CLOCK, 0, 0, 1601);
    send_event(MODE_LENGTH, 0, 6'd1, 0);
    send_event(MODE_LENGTH, 0, 6'd63, 0);
    send_event(MODE_RESET, 0, 0, 0);
    send_event(MODE_LENGTH, 0, 6'd0, 0);
    send_event(3'd5, 5'd31, 6'd63, 19'h7ffff);
    send_event(3'd7, 0, 0, 0);
    drain();
    write_reg(REG_CHANCE, 0);
    write_reg(REG_RATCHET, 256);
    write_reg(REG_SPREAD, 256);
    write_reg(REG_PITCH, 32'h3fff);
    send_event(MODE_CLOCK, 0, 0, 1600);
    send_event(MODE_HAND, 0, 0, 0);
    send_event(MODE_CLOCK, 0, 0, 1601);
    drain();
    write_reg(REG_CHANCE, 256);
    write_reg(REG_TONE, 511);
    write_reg(REG_PITCH, 32'h6000);
    repeat (6) send_event(MODE_CLOCK, 0, 0, 19'h7ffff);

    // random phases over register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(REG_SEED, ph == 0 ? 32'hffffffff : ph == 1 ? 0 : $urandom);
      write_reg(REG_CHANCE, ph == 2 ? 0 : ph == 3 ? 511 : $urandom_range(0, 300));
      write_reg(REG_SPREAD, ph == 2 ? 0 : ph == 3 ? 511 : $urandom_range(0, 300));
      write_reg(REG_TONE, ph == 4 ? 0 : ph == 5 ? 511 : $urandom_range(0, 300));
      write_reg(REG_PITCH, ph == 4 ? 32'h6000 : ph == 5 ? 32'h3fff : $urandom);
      write_reg(REG_RATCHET, ph == 6 ? 0 : ph == 7 ? 511 : $urandom_range(0, 511));
      stall_free = (ph == 5);
      repeat (200) random_event();
    end
    drain();
    $display("run covered %0d events and %0d checked results over eight register settings",
             sent, sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
